[hdl/sobb_pkg.sv]
// ============================================================================
// sobb_pkg: shared types and constants for the opaque bounding box block
// Sizes, channel widths, configuration register indexes, side clamp helper.
// ============================================================================
`default_nettype none

package sobb_pkg;

    // Largest image side; counters hold 0..MAX_SIDE-1, sides hold 1..MAX_SIDE
    localparam int MAX_SIDE   = 4096;
    localparam int CNT_W      = $clog2(MAX_SIDE);
    localparam int SIDE_W     = CNT_W + 1;

    localparam int CHAN_W     = 16;
    localparam int HOT_W      = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USE_MASK     = CFG_IDX_W'(0),
        CFG_KEY_RED      = CFG_IDX_W'(1),
        CFG_KEY_GREEN    = CFG_IDX_W'(2),
        CFG_KEY_BLUE     = CFG_IDX_W'(3),
        CFG_IMAGE_WIDTH  = CFG_IDX_W'(4),
        CFG_IMAGE_HEIGHT = CFG_IDX_W'(5),
        CFG_HOT_X        = CFG_IDX_W'(6),
        CFG_HOT_Y        = CFG_IDX_W'(7)
    } t_cfg_reg;

    // Zero acts as one, anything above MAX_SIDE acts as MAX_SIDE
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] res;
        if (v == '0) begin
            res = SIDE_W'(1);
        end else if (v > SIDE_W'(MAX_SIDE)) begin
            res = SIDE_W'(MAX_SIDE);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[hdl/sobb_if.sv]
// ============================================================================
// sobb_if: channel interfaces of the opaque bounding box block
// Pixel input, box result and configuration write channels, valid/ready.
// ============================================================================
`default_nettype none

// Pixel channel: one pixel per transfer, raster order
interface sobb_pix_if import sobb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] pix_red;
    logic [CHAN_W-1:0] pix_green;
    logic [CHAN_W-1:0] pix_blue;

    modport source (output valid, output pix_red, output pix_green, output pix_blue,
                    input ready);
    modport sink   (input valid, input pix_red, input pix_green, input pix_blue,
                    output ready);
endinterface

// Result channel: one box per image
interface sobb_box_if import sobb_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [SIDE_W-1:0]       box_left;
    logic [SIDE_W-1:0]       box_top;
    logic [SIDE_W-1:0]       box_right;
    logic [SIDE_W-1:0]       box_bottom;
    logic signed [HOT_W-1:0] new_hot_x;
    logic signed [HOT_W-1:0] new_hot_y;
    logic                    any_opaque;

    modport source (output valid, output box_left, output box_top, output box_right,
                    output box_bottom, output new_hot_x, output new_hot_y,
                    output any_opaque, input ready);
    modport sink   (input valid, input box_left, input box_top, input box_right,
                    input box_bottom, input new_hot_x, input new_hot_y,
                    input any_opaque, output ready);
endinterface

// Configuration write channel
interface sobb_cfg_if import sobb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/sprite_opaque_bounding_box.sv]
// ============================================================================
// sprite_opaque_bounding_box: tight box around the opaque pixels of an image
// Streams one image in raster order and reports the trimmed box and hotspot.
// ============================================================================
// Pixels enter one per clock unless stalled, through a valid/ready channel; each transfer
// lands in an input register, from which a single pass of compares and
// min/max updates folds it into the running box once the result side can
// advance. The sustained rate is one pixel per cycle while boxes are taken.
// The last pixel of an image passes from the input register into the result
// register, from which the box is offered. While a box waits to be taken,
// only one pixel of the next image can enter the input register; the input
// stalls only when both the input register and the result register are full
// and the result is not taken. An image with no opaque pixel reports the
// full image and the unchanged hotspot with any_opaque low. Configuration
// writes are always accepted and should be made only while no image is in
// flight; width and height of 0 act as 1, values from 4097 to 8191 act as
// 4096, and only the low 13 bits of a written size are kept.
`default_nettype none

module sprite_opaque_bounding_box import sobb_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    sobb_cfg_if.sink   i_cfg,
    sobb_pix_if.sink   i_pix,
    sobb_box_if.source o_box
);

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic              r_use_mask;
    logic [CHAN_W-1:0] r_key_red;
    logic [CHAN_W-1:0] r_key_green;
    logic [CHAN_W-1:0] r_key_blue;
    logic [SIDE_W-1:0] r_image_width;
    logic [SIDE_W-1:0] r_image_height;
    logic [HOT_W-1:0]  r_hot_x;
    logic [HOT_W-1:0]  r_hot_y;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_mask     <= 1'b0;
            r_key_red      <= '0;
            r_key_green    <= '0;
            r_key_blue     <= '0;
            r_image_width  <= SIDE_W'(1);
            r_image_height <= SIDE_W'(1);
            r_hot_x        <= '0;
            r_hot_y        <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_USE_MASK:     r_use_mask     <= i_cfg.data[0];
                CFG_KEY_RED:      r_key_red      <= i_cfg.data[CHAN_W-1:0];
                CFG_KEY_GREEN:    r_key_green    <= i_cfg.data[CHAN_W-1:0];
                CFG_KEY_BLUE:     r_key_blue     <= i_cfg.data[CHAN_W-1:0];
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg.data[SIDE_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg.data[SIDE_W-1:0];
                CFG_HOT_X:        r_hot_x        <= i_cfg.data[HOT_W-1:0];
                CFG_HOT_Y:        r_hot_y        <= i_cfg.data[HOT_W-1:0];
                default:          ; // indexes past the list are ignored
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Handshake: result register frees up when empty or taken
    // ------------------------------------------------------------------------
    logic r_pix_valid;
    logic r_out_valid;
    logic advance;
    logic proc;

    assign advance     = !r_out_valid || o_box.ready;
    assign i_pix.ready = !r_pix_valid || advance;
    assign proc        = r_pix_valid && advance;

    // ------------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------------
    logic [CHAN_W-1:0] r_red;
    logic [CHAN_W-1:0] r_green;
    logic [CHAN_W-1:0] r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_pix_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_red   <= i_pix.pix_red;
            r_green <= i_pix.pix_green;
            r_blue  <= i_pix.pix_blue;
        end
    end

    // ------------------------------------------------------------------------
    // Running box state
    // ------------------------------------------------------------------------
    logic [CNT_W-1:0] r_col_count;
    logic [CNT_W-1:0] r_row_count;
    logic [CNT_W-1:0] r_min_col;
    logic [CNT_W-1:0] r_max_col;
    logic [CNT_W-1:0] r_min_row;
    logic [CNT_W-1:0] r_max_row;
    logic             r_seen;

    logic [SIDE_W-1:0] side_w;
    logic [SIDE_W-1:0] side_h;
    logic              opaque;
    logic              row_end;
    logic              img_end;
    logic              seen_now;
    logic [CNT_W-1:0]  n_min_col;
    logic [CNT_W-1:0]  n_max_col;
    logic [CNT_W-1:0]  n_min_row;
    logic [CNT_W-1:0]  n_max_row;

    assign side_w = clamp_side(r_image_width);
    assign side_h = clamp_side(r_image_height);

    // Opacity test: mask mode or key colour compare
    always_comb begin
        if (r_use_mask) begin
            opaque = (r_red != '0) || (r_green != '0) || (r_blue != '0);
        end else begin
            opaque = (r_red != r_key_red) || (r_green != r_key_green)
                  || (r_blue != r_key_blue);
        end
    end

    // Extent update; first opaque pixel seeds the min and max of both column and row
    always_comb begin
        n_min_col = r_min_col;
        n_max_col = r_max_col;
        n_min_row = r_min_row;
        n_max_row = r_max_row;
        if (opaque) begin
            if (!r_seen || r_col_count < r_min_col) n_min_col = r_col_count;
            if (!r_seen || r_col_count > r_max_col) n_max_col = r_col_count;
            if (!r_seen || r_row_count < r_min_row) n_min_row = r_row_count;
            if (!r_seen || r_row_count > r_max_row) n_max_row = r_row_count;
        end
    end

    assign seen_now = r_seen || opaque;
    assign row_end  = ({1'b0, r_col_count} + SIDE_W'(1)) >= side_w;
    assign img_end  = row_end && (({1'b0, r_row_count} + SIDE_W'(1)) >= side_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= '0;
            r_row_count <= '0;
            r_min_col   <= '0;
            r_max_col   <= '0;
            r_min_row   <= '0;
            r_max_row   <= '0;
            r_seen      <= 1'b0;
        end else if (proc) begin
            if (img_end) begin
                // image done: clear for the next one
                r_col_count <= '0;
                r_row_count <= '0;
                r_min_col   <= '0;
                r_max_col   <= '0;
                r_min_row   <= '0;
                r_max_row   <= '0;
                r_seen      <= 1'b0;
            end else begin
                r_min_col <= n_min_col;
                r_max_col <= n_max_col;
                r_min_row <= n_min_row;
                r_max_row <= n_max_row;
                r_seen    <= seen_now;
                if (row_end) begin
                    r_col_count <= '0;
                    r_row_count <= r_row_count + CNT_W'(1);
                end else begin
                    r_col_count <= r_col_count + CNT_W'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------------
    logic [SIDE_W-1:0] r_box_left;
    logic [SIDE_W-1:0] r_box_top;
    logic [SIDE_W-1:0] r_box_right;
    logic [SIDE_W-1:0] r_box_bottom;
    logic [HOT_W-1:0]  r_new_hot_x;
    logic [HOT_W-1:0]  r_new_hot_y;
    logic              r_any_opaque;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= proc && img_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && img_end) begin
            r_any_opaque <= seen_now;
            if (seen_now) begin
                r_box_left   <= {1'b0, n_min_col};
                r_box_top    <= {1'b0, n_min_row};
                r_box_right  <= {1'b0, n_max_col} + SIDE_W'(1);
                r_box_bottom <= {1'b0, n_max_row} + SIDE_W'(1);
                r_new_hot_x  <= r_hot_x - HOT_W'(n_min_col);
                r_new_hot_y  <= r_hot_y - HOT_W'(n_min_row);
            end else begin
                // nothing opaque: whole image, hotspot untouched
                r_box_left   <= '0;
                r_box_top    <= '0;
                r_box_right  <= side_w;
                r_box_bottom <= side_h;
                r_new_hot_x  <= r_hot_x;
                r_new_hot_y  <= r_hot_y;
            end
        end
    end

    assign o_box.valid      = r_out_valid;
    assign o_box.box_left   = r_box_left;
    assign o_box.box_top    = r_box_top;
    assign o_box.box_right  = r_box_right;
    assign o_box.box_bottom = r_box_bottom;
    assign o_box.new_hot_x  = r_new_hot_x;
    assign o_box.new_hot_y  = r_new_hot_y;
    assign o_box.any_opaque = r_any_opaque;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && img_end |=> (r_col_count == '0) && (r_row_count == '0) && !r_seen)
        else $error("box state not cleared after image end");

    a_extent_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |-> (r_min_col <= r_max_col) && (r_min_row <= r_max_row))
        else $error("running extent out of order");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> r_pix_valid && r_out_valid && !o_box.ready)
        else $error("pixel input stalled without a full pipeline");

    a_box_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_any_opaque |->
            (r_box_right > r_box_left) && (r_box_bottom > r_box_top))
        else $error("opaque box is empty");

    a_transparent_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_any_opaque |->
            (r_box_left == '0) && (r_box_top == '0) && (r_box_right != '0))
        else $error("transparent image box not the full image");

endmodule

`default_nettype wire
